// File: rtl/chd_pkg.sv
// ----------------------------------------------------------------------------
// chd_pkg
// Shared types, constants and the arctangent table for the compass heading core.
// ----------------------------------------------------------------------------
package chd_pkg;

  localparam int MAG_W  = 16;
  localparam int ANG_W  = 16;
  localparam int XY_W   = 20;
  localparam int DEG_W  = 9;
  localparam int DECL_W = 16;
  localparam int BAND_W = 4;
  localparam int ATAN_IDX_W = 5;

  localparam logic [ANG_W-1:0]  HALF_TURN    = 16'h8000;
  localparam logic [DEG_W-1:0]  DEG_PER_TURN = 9'd360;
  localparam logic [DEG_W-1:0]  SEG_SPLIT    = 9'd240;
  localparam logic [7:0]        SEG1_NUM     = 8'd179;
  localparam logic [1:0]        SEG2_MUL     = 2'd3;
  localparam logic [DEG_W-1:0]  SEG2_BASE    = 9'd180;
  localparam logic [16:0]       RECIP_239    = 17'd70198;
  localparam int                RECIP_SHIFT  = 24;
  localparam logic [BAND_W-1:0] BAND_RST     = 4'd3;

  localparam logic REG_DECL = 1'b0;
  localparam logic REG_BAND = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_sts_t;

  function automatic logic [ANG_W-1:0] atan_bau(input logic [ATAN_IDX_W-1:0] idx);
    logic [ANG_W-1:0] v;
    unique case (idx)
      5'd0:    v = 16'd8192;
      5'd1:    v = 16'd4836;
      5'd2:    v = 16'd2555;
      5'd3:    v = 16'd1297;
      5'd4:    v = 16'd651;
      5'd5:    v = 16'd326;
      5'd6:    v = 16'd163;
      5'd7:    v = 16'd81;
      5'd8:    v = 16'd41;
      5'd9:    v = 16'd20;
      5'd10:   v = 16'd10;
      5'd11:   v = 16'd5;
      5'd12:   v = 16'd3;
      5'd13:   v = 16'd1;
      5'd14:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/chd_in_if.sv
// ----------------------------------------------------------------------------
// chd_in_if
// Input channel: one magnetometer X/Y pair per item.
// ----------------------------------------------------------------------------
interface chd_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [chd_pkg::MAG_W-1:0]    mag_x;
  logic signed [chd_pkg::MAG_W-1:0]    mag_y;

  modport source (output valid, output mag_x, output mag_y, input ready);
  modport sink   (input valid, input mag_x, input mag_y, output ready);
endinterface

// File: rtl/chd_out_if.sv
// ----------------------------------------------------------------------------
// chd_out_if
// Result channel: one heading in whole degrees per item.
// ----------------------------------------------------------------------------
interface chd_out_if;
  logic                        valid;
  logic                        ready;
  logic [chd_pkg::DEG_W-1:0]   heading_degrees;

  modport source (output valid, output heading_degrees, input ready);
  modport sink   (input valid, input heading_degrees, output ready);
endinterface

// File: rtl/chd_cordic.sv
// ----------------------------------------------------------------------------
// chd_cordic
// Vectoring CORDIC, one micro-rotation per cycle on a shared shift/add unit.
// ----------------------------------------------------------------------------
module chd_cordic #(
  parameter int STEPS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [chd_pkg::MAG_W-1:0] x_in,
  input  logic signed [chd_pkg::MAG_W-1:0] y_in,
  output logic [chd_pkg::ANG_W-1:0]        z_out,
  output chd_pkg::cordic_sts_t             sts
);

  localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int XW = chd_pkg::XY_W;

  logic signed [XW-1:0]          x_r, x_nxt;
  logic signed [XW-1:0]          y_r, y_nxt;
  logic [chd_pkg::ANG_W-1:0]     z_r, z_nxt;
  logic [IW-1:0]                 cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic                          zero_r, zero_nxt;
  logic signed [XW-1:0]          x_ext, y_ext, xs, ys;
  logic [chd_pkg::ANG_W-1:0]     step_ang;
  logic                          y_pos;

  always_comb begin
    x_ext    = {{(XW-chd_pkg::MAG_W){x_in[chd_pkg::MAG_W-1]}}, x_in};
    y_ext    = {{(XW-chd_pkg::MAG_W){y_in[chd_pkg::MAG_W-1]}}, y_in};
    xs       = x_r >>> cnt_r;
    ys       = y_r >>> cnt_r;
    step_ang = chd_pkg::atan_bau(chd_pkg::ATAN_IDX_W'(cnt_r));
    y_pos    = !y_r[XW-1] && (y_r != '0);

    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    zero_nxt = zero_r;

    if (start) begin
      zero_nxt = (x_in == '0) && (y_in == '0);
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      if (x_in[chd_pkg::MAG_W-1]) begin
        x_nxt = -x_ext;
        y_nxt = -y_ext;
        z_nxt = chd_pkg::HALF_TURN;
      end else begin
        x_nxt = x_ext;
        y_nxt = y_ext;
        z_nxt = '0;
      end
    end else if (busy_r) begin
      if (y_pos) begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + step_ang;
      end else begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - step_ang;
      end
      if (cnt_r == IW'(STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    cnt_r  <= cnt_nxt;
    zero_r <= zero_nxt;
  end

  assign z_out    = zero_r ? '0 : z_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

// File: rtl/compass_heading_deadband_core.sv
// path: cordic, then S_DEG, S_MUL, S_DIV and S_BAND; S_BAND waits on the output
// one item at a time: a new one is taken only in S_IDLE, and each runs on the single
//   shared cordic shift/add unit, one micro-rotation a cycle
// a finished result may wait on the output while the next item is taken
// reset (synchronous, rst_n low): idle, declination 0, deadband 3, last heading 0
// ----------------------------------------------------------------------------
// compass_heading_deadband_core
// Magnetometer atan2 heading with declination, degree remap and deadband hold.
// ----------------------------------------------------------------------------
module compass_heading_deadband_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  chd_in_if.sink             in_ch,
  chd_out_if.source          out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CORDIC = 6'b000010,
    S_DEG    = 6'b000100,
    S_MUL    = 6'b001000,
    S_DIV    = 6'b010000,
    S_BAND   = 6'b100000
  } state_t;

  localparam int DW = chd_pkg::DEG_W;

  state_t                          state_r, state_nxt;
  logic [chd_pkg::DECL_W-1:0]      decl_r;
  logic [chd_pkg::BAND_W-1:0]      band_r;
  logic [DW-1:0]                   last_r, last_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [chd_pkg::ANG_W-1:0]       bau_r, bau_nxt;
  logic [DW-1:0]                   deg_r, deg_nxt;
  logic [15:0]                     num_r, num_nxt;
  logic                            seg1_r, seg1_nxt;
  logic [DW-1:0]                   fixed_r, fixed_nxt;

  logic                            in_acc;
  logic                            cfg_wr;
  logic [chd_pkg::ANG_W-1:0]       cordic_z;
  chd_pkg::cordic_sts_t            cordic_sts;
  logic [24:0]                     deg_prod;
  logic [32:0]                     div_prod;
  logic signed [DW+1:0]            band_diff, band_s;
  logic                            hold;

  chd_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .x_in  (in_ch.mag_x),
    .y_in  (in_ch.mag_y),
    .z_out (cordic_z),
    .sts   (cordic_sts)
  );

  assign in_ch.ready            = (state_r == S_IDLE);
  assign in_acc                 = in_ch.valid && in_ch.ready;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.heading_degrees = last_r;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  always_comb begin
    unique case (paddr[2])
      chd_pkg::REG_DECL: prdata = {{(32-chd_pkg::DECL_W){decl_r[chd_pkg::DECL_W-1]}}, decl_r};
      chd_pkg::REG_BAND: prdata = {{(32-chd_pkg::BAND_W){1'b0}}, band_r};
      default:           prdata = '0;
    endcase
  end

  always_comb begin
    deg_prod  = 25'(bau_r) * 25'(chd_pkg::DEG_PER_TURN);
    div_prod  = 33'(num_r) * 33'(chd_pkg::RECIP_239);
    band_diff = $signed({2'b00, fixed_r}) - $signed({2'b00, last_r});
    band_s    = $signed({{(DW+2-chd_pkg::BAND_W){1'b0}}, band_r});
    hold      = (band_diff < band_s) && (band_diff > -band_s);

    state_nxt     = state_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    bau_nxt       = bau_r;
    deg_nxt       = deg_r;
    num_nxt       = num_r;
    seg1_nxt      = seg1_r;
    fixed_nxt     = fixed_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_CORDIC;
      end
      S_CORDIC: begin
        if (cordic_sts.done) begin
          bau_nxt   = cordic_z + decl_r;
          state_nxt = S_DEG;
        end
      end
      S_DEG: begin
        deg_nxt   = deg_prod[24:16];
        state_nxt = S_MUL;
      end
      S_MUL: begin
        seg1_nxt = (deg_r < chd_pkg::SEG_SPLIT);
        if (deg_r < chd_pkg::SEG_SPLIT) begin
          num_nxt = 16'(deg_r) * 16'(chd_pkg::SEG1_NUM);
        end else begin
          num_nxt = 16'(deg_r - chd_pkg::SEG_SPLIT) * 16'(chd_pkg::SEG2_MUL);
        end
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (seg1_r) begin
          fixed_nxt = div_prod[chd_pkg::RECIP_SHIFT +: DW];
        end else begin
          fixed_nxt = DW'(num_r >> 1) + chd_pkg::SEG2_BASE;
        end
        state_nxt = S_BAND;
      end
      S_BAND: begin
        if (!out_valid_r || out_ch.ready) begin
          last_nxt      = hold ? last_r : fixed_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      decl_r      <= '0;
      band_r      <= chd_pkg::BAND_RST;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr && (paddr[2] == chd_pkg::REG_DECL)) decl_r <= pwdata[chd_pkg::DECL_W-1:0];
      if (cfg_wr && (paddr[2] == chd_pkg::REG_BAND)) band_r <= pwdata[chd_pkg::BAND_W-1:0];
    end
    bau_r   <= bau_nxt;
    deg_r   <= deg_nxt;
    num_r   <= num_nxt;
    seg1_r  <= seg1_nxt;
    fixed_r <= fixed_nxt;
  end

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_CORDIC) && cordic_sts.busy)
    else $error("accepted item did not start the cordic");

  a_busy_in_cordic: assert property (@(posedge clk) disable iff (!rst_n)
    cordic_sts.busy |-> (state_r == S_CORDIC))
    else $error("cordic busy outside its state");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cordic_sts.done |-> $past(cordic_sts.busy))
    else $error("cordic done without a run");

  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    last_r <= 9'd358)
    else $error("heading out of range");

  a_band_issues: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BAND) && (!out_valid_r || out_ch.ready) |=> out_valid_r && (state_r == S_IDLE))
    else $error("result not issued");
`endif

endmodule
